/* hdl/u8cpd_pkg.sv */
// package for the utf-8 code point decoder: byte class constants, result
// burst type and code point constants; no dependencies
`timescale 1ns / 1ps

package u8cpd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CP_W     = 21;
    localparam int unsigned SEQ_W    = 3;
    localparam int unsigned CONT_W   = 2;
    localparam int unsigned FFFD_W   = 2;
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 24;

    localparam logic [CP_W-1:0]   CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [CP_W-1:0]   CP_ZERO        = '0;

    // sequence lengths held in the decoder state
    localparam logic [SEQ_W-1:0]  SEQ_NONE = 3'd0;
    localparam logic [SEQ_W-1:0]  SEQ_TWO  = 3'd2;
    localparam logic [SEQ_W-1:0]  SEQ_THREE = 3'd3;
    localparam logic [SEQ_W-1:0]  SEQ_FOUR = 3'd4;

    // byte class masks and patterns
    localparam logic [BYTE_W-1:0] MASK_C0 = 8'hC0;
    localparam logic [BYTE_W-1:0] PAT_80  = 8'h80;
    localparam logic [BYTE_W-1:0] MASK_E0 = 8'hE0;
    localparam logic [BYTE_W-1:0] PAT_C0  = 8'hC0;
    localparam logic [BYTE_W-1:0] MASK_F0 = 8'hF0;
    localparam logic [BYTE_W-1:0] PAT_E0  = 8'hE0;
    localparam logic [BYTE_W-1:0] MASK_F8 = 8'hF8;
    localparam logic [BYTE_W-1:0] PAT_F0  = 8'hF0;
    localparam logic [BYTE_W-1:0] LOW6    = 8'h3F;
    localparam logic [BYTE_W-1:0] LOW5    = 8'h1F;
    localparam logic [BYTE_W-1:0] LOW4    = 8'h0F;
    localparam logic [BYTE_W-1:0] LOW3    = 8'h07;

    // all results caused by one byte: some replacement beats, then an
    // optional tail beat
    typedef struct packed {
        logic [FFFD_W-1:0] fffd_cnt;
        logic              tail_valid;
        logic [CP_W-1:0]   tail_cp;
        logic              tail_end;
    } t_burst;

endpackage

/* hdl/utf8_code_point_decoder.sv */
// top level of the utf-8 code point decoder: input byte register, decoder
// state with burst decode, and result register; depends on u8cpd_pkg,
// u8cpd_decode and u8cpd_emit
`timescale 1ns / 1ps

//  port group   dir   beat contents
//  s_axis       in    tdata[7:0] text byte, zero ends the text
//  m_axis       out   tdata[20:0] code point, tuser end of text,
//                     tlast final result of its byte
//
// one byte is taken per cycle while m_axis does not stall; a byte that yields
// one result sustains one beat per cycle, a broken sequence holds the input
// while the result register plays out its burst (up to four beats from one
// byte), one beat a cycle
// the input byte register takes a byte while a result waits at the output
// synchronous active-low reset clears the sequence state and both registers
// stalls on m_axis back up into the byte register, then into s_axis tready

module utf8_code_point_decoder (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [u8cpd_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // [7:0] text_byte
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [u8cpd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // [20:0] code_point
    output logic                                 m_axis_tuser,  // [0] end_of_text
    output logic                                 m_axis_tlast
);
    import u8cpd_pkg::*;

    // input byte register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    t_burst            burst;
    logic              can_load;
    logic              load;
    logic [CP_W-1:0]   out_cp;

    // byte moves into the decoder when the result register frees up
    assign load          = r_in_valid && can_load;
    assign s_axis_tready = !r_in_valid || can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata[BYTE_W-1:0];
        end
    end

    // sequence state and decode of the held byte
    u8cpd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_byte  (r_in_byte),
        .o_burst (burst)
    );

    // burst playout
    u8cpd_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load_req (r_in_valid),
        .i_burst    (burst),
        .i_ready    (m_axis_tready),
        .o_can_load (can_load),
        .o_valid    (m_axis_tvalid),
        .o_cp       (out_cp),
        .o_end      (m_axis_tuser),
        .o_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {(OUT_DATA_W - CP_W)'(0), out_cp};

    // end item always carries a zero code point
    a_end_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[CP_W-1:0] == CP_ZERO))
        else $error("end item with nonzero code point");

    // an end item is always the final beat of its byte
    a_end_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("end item not marked last");

    // a burst never has a gap between its beats
    a_burst_cont : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("gap inside result burst");

    // input held off only while a byte waits in the byte register
    a_ready_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && m_axis_tvalid))
        else $error("input stalled with nothing pending");

endmodule

/* hdl/u8cpd_decode.sv */
// sequence state and one-pass byte decode into a result burst
// depends on u8cpd_pkg
`timescale 1ns / 1ps

module u8cpd_decode (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  logic [u8cpd_pkg::BYTE_W-1:0]   i_byte,
    output u8cpd_pkg::t_burst              o_burst
);
    import u8cpd_pkg::*;

    logic [SEQ_W-1:0]  r_seq_len, n_seq_len;
    logic [CONT_W-1:0] r_cont, n_cont;
    logic [CP_W-1:0]   r_pv, n_pv;

    logic              pending;
    logic              is_cont;
    logic [CONT_W-1:0] cont_inc;
    logic [CP_W-1:0]   pv_shift;

    assign pending  = (r_seq_len != SEQ_NONE);
    assign is_cont  = ((i_byte & MASK_C0) == PAT_80);
    assign cont_inc = r_cont + CONT_W'(1);
    assign pv_shift = {r_pv[CP_W-7:0], i_byte[5:0]};

    always_comb begin
        n_seq_len        = r_seq_len;
        n_cont           = r_cont;
        n_pv             = r_pv;
        o_burst.fffd_cnt = '0;
        o_burst.tail_valid = 1'b0;
        o_burst.tail_cp  = CP_ZERO;
        o_burst.tail_end = 1'b0;
        if (pending && is_cont) begin
            n_pv   = pv_shift;
            n_cont = cont_inc;
            if (({1'b0, cont_inc} + SEQ_W'(1)) >= r_seq_len) begin
                o_burst.tail_valid = 1'b1;
                o_burst.tail_cp    = pv_shift;
                n_seq_len = SEQ_NONE;
                n_cont    = '0;
                n_pv      = '0;
            end
        end else begin
            // broken sequence: one replacement for the lead and each continuation
            if (pending) begin
                o_burst.fffd_cnt = (r_cont == 2'd3) ? 2'd3 : cont_inc;
            end
            n_seq_len = SEQ_NONE;
            n_cont    = '0;
            n_pv      = '0;
            priority if (i_byte == '0) begin
                o_burst.tail_valid = 1'b1;
                o_burst.tail_end   = 1'b1;
            end else if (!i_byte[7]) begin
                o_burst.tail_valid = 1'b1;
                o_burst.tail_cp    = CP_W'(i_byte);
            end else if (is_cont) begin
                o_burst.tail_valid = 1'b1;
                o_burst.tail_cp    = CP_REPLACEMENT;
            end else if ((i_byte & MASK_E0) == PAT_C0) begin
                n_seq_len = SEQ_TWO;
                n_pv      = CP_W'(i_byte & LOW5);
            end else if ((i_byte & MASK_F0) == PAT_E0) begin
                n_seq_len = SEQ_THREE;
                n_pv      = CP_W'(i_byte & LOW4);
            end else if ((i_byte & MASK_F8) == PAT_F0) begin
                n_seq_len = SEQ_FOUR;
                n_pv      = CP_W'(i_byte & LOW3);
            end else begin
                o_burst.tail_valid = 1'b1;
                o_burst.tail_cp    = CP_REPLACEMENT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_len <= SEQ_NONE;
            r_cont    <= '0;
            r_pv      <= '0;
        end else if (i_load) begin
            r_seq_len <= n_seq_len;
            r_cont    <= n_cont;
            r_pv      <= n_pv;
        end
    end

endmodule

/* hdl/u8cpd_emit.sv */
// result register: holds one byte's burst and plays it out one beat a cycle
// while i_ready is high; depends on u8cpd_pkg
`timescale 1ns / 1ps

module u8cpd_emit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load_req,
    input  u8cpd_pkg::t_burst            i_burst,
    input  logic                         i_ready,
    output logic                         o_can_load,
    output logic                         o_valid,
    output logic [u8cpd_pkg::CP_W-1:0]   o_cp,
    output logic                         o_end,
    output logic                         o_last
);
    import u8cpd_pkg::*;

    logic [FFFD_W-1:0] r_fffd, n_fffd;
    logic              r_tail_valid, n_tail_valid;
    logic [CP_W-1:0]   r_tail_cp;
    logic              r_tail_end;
    logic              beat;
    logic              load;

    assign o_valid    = (r_fffd != '0) || r_tail_valid;
    assign o_last     = (r_fffd == '0) || ((r_fffd == FFFD_W'(1)) && !r_tail_valid);
    assign o_cp       = (r_fffd != '0) ? CP_REPLACEMENT : r_tail_cp;
    assign o_end      = (r_fffd == '0) && r_tail_end;
    assign beat       = o_valid && i_ready;
    assign o_can_load = !o_valid || (beat && o_last);
    assign load       = i_load_req && o_can_load;

    always_comb begin
        n_fffd       = r_fffd;
        n_tail_valid = r_tail_valid;
        if (load) begin
            n_fffd       = i_burst.fffd_cnt;
            n_tail_valid = i_burst.tail_valid;
        end else if (beat) begin
            if (r_fffd != '0) begin
                n_fffd = r_fffd - FFFD_W'(1);
            end else begin
                n_tail_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fffd       <= '0;
            r_tail_valid <= 1'b0;
        end else begin
            r_fffd       <= n_fffd;
            r_tail_valid <= n_tail_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tail_cp  <= i_burst.tail_cp;
            r_tail_end <= i_burst.tail_end;
        end
    end

endmodule

/* sim/tb_utf8_code_point_decoder.sv */
// self-checking testbench for utf8_code_point_decoder: directed byte table, then
// random utf-8 text under several idle/stall mixes, checked by a local decoder
// model; depends on u8cpd_pkg and utf8_code_point_decoder
`timescale 1ns / 1ps

module tb_utf8_code_point_decoder;
    import u8cpd_pkg::*;

    // one result beat as the decoder should produce it
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            eot;
        logic            last;
    } t_cp_result;

    // directed row: byte to send, and a typed-in result where it is obvious
    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              typed;
        logic [CP_W-1:0]   cp;
        logic              eot;
    } t_text_row;

    localparam int N_DIRECTED = 25;
    localparam int BYTES_PER_PHASE = 24;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [7:0] text_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // [20:0] code_point
    logic                  m_axis_tuser;        // [0] end_of_text
    logic                  m_axis_tlast;

    // decoder model state
    logic [SEQ_W-1:0]  dec_seq_len = SEQ_NONE;
    logic [CONT_W-1:0] dec_cont_seen = '0;
    logic [CP_W-1:0]   dec_partial = '0;

    t_cp_result byte_results[$];   // results of the byte just decoded
    t_cp_result cp_expected[$];    // results still owed by the block

    // what the sender currently presents, read by the monitor on acceptance
    logic            cur_typed = 1'b0;
    logic [CP_W-1:0] cur_cp = '0;
    logic            cur_eot = 1'b0;

    int idle_pct = 0;
    int stall_pct = 0;
    int errors = 0;

    // directed text: ascii and invalid bytes typed in, multi-byte runs predicted
    t_text_row directed_rows [0:N_DIRECTED-1] = '{
        '{8'h00, 1'b1, CP_ZERO,        1'b1},   // end of text right after reset
        '{8'h41, 1'b1, 21'h000041,     1'b0},
        '{8'h7F, 1'b1, 21'h00007F,     1'b0},   // top of ascii
        '{8'h80, 1'b1, CP_REPLACEMENT, 1'b0},   // stray continuation
        '{8'hBF, 1'b1, CP_REPLACEMENT, 1'b0},
        '{8'hF8, 1'b1, CP_REPLACEMENT, 1'b0},   // invalid leads
        '{8'hFF, 1'b1, CP_REPLACEMENT, 1'b0},
        '{8'hC2, 1'b0, CP_ZERO,        1'b0},   // two-byte sequence
        '{8'hA9, 1'b0, CP_ZERO,        1'b0},
        '{8'hE2, 1'b0, CP_ZERO,        1'b0},   // three-byte sequence
        '{8'h82, 1'b0, CP_ZERO,        1'b0},
        '{8'hAC, 1'b0, CP_ZERO,        1'b0},
        '{8'hF7, 1'b0, CP_ZERO,        1'b0},   // lead past f4, all ones payload
        '{8'hBF, 1'b0, CP_ZERO,        1'b0},
        '{8'hBF, 1'b0, CP_ZERO,        1'b0},
        '{8'hBF, 1'b0, CP_ZERO,        1'b0},
        '{8'hF0, 1'b0, CP_ZERO,        1'b0},   // four-byte run broken by ascii
        '{8'h9F, 1'b0, CP_ZERO,        1'b0},
        '{8'h98, 1'b0, CP_ZERO,        1'b0},
        '{8'h41, 1'b0, CP_ZERO,        1'b0},   // four results from one byte
        '{8'hE2, 1'b0, CP_ZERO,        1'b0},   // pending lead flushed by nul
        '{8'h00, 1'b0, CP_ZERO,        1'b0},
        '{8'hC2, 1'b0, CP_ZERO,        1'b0},   // lead broken by another lead
        '{8'hC3, 1'b0, CP_ZERO,        1'b0},
        '{8'hA9, 1'b0, CP_ZERO,        1'b0}
    };

    utf8_code_point_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    function automatic void add_result(input logic [CP_W-1:0] cp, input logic eot);
        t_cp_result item;
        item.cp      = cp;
        item.eot     = eot;
        item.last    = 1'b0;
        byte_results = {byte_results, item};
    endfunction

    function automatic void clear_sequence();
        dec_seq_len   = SEQ_NONE;
        dec_cont_seen = '0;
        dec_partial   = '0;
    endfunction

    // decode one text byte into byte_results and advance the model state
    function automatic void decode_byte(input logic [BYTE_W-1:0] b);
        byte_results.delete();
        if (dec_seq_len != SEQ_NONE && (b & MASK_C0) == PAT_80) begin
            // continuation adds six bits, the last one completes the code point
            dec_partial   = {dec_partial[CP_W-7:0], b[5:0]};
            dec_cont_seen = dec_cont_seen + 1'b1;
            if (dec_cont_seen + 1 >= dec_seq_len) begin
                add_result(dec_partial, 1'b0);
                clear_sequence();
            end
        end else begin
            if (dec_seq_len != SEQ_NONE) begin
                // broken run: one replacement for the lead and each continuation
                for (int k = 0; k <= dec_cont_seen && byte_results.size() < 3; k++)
                    add_result(CP_REPLACEMENT, 1'b0);
                clear_sequence();
            end
            if (b == '0) begin
                add_result(CP_ZERO, 1'b1);
            end else if (!b[7]) begin
                add_result(CP_W'(b), 1'b0);
            end else if ((b & MASK_C0) == PAT_80) begin
                add_result(CP_REPLACEMENT, 1'b0);
            end else if ((b & MASK_E0) == PAT_C0) begin
                dec_seq_len = SEQ_TWO;
                dec_partial = CP_W'(b & LOW5);
            end else if ((b & MASK_F0) == PAT_E0) begin
                dec_seq_len = SEQ_THREE;
                dec_partial = CP_W'(b & LOW4);
            end else if ((b & MASK_F8) == PAT_F0) begin
                dec_seq_len = SEQ_FOUR;
                dec_partial = CP_W'(b & LOW3);
            end else begin
                add_result(CP_REPLACEMENT, 1'b0);
            end
        end
        if (byte_results.size() > 0) begin
            byte_results[byte_results.size() - 1].last = 1'b1;
        end
    endfunction

    // receiver: random stalls, decided at the falling edge
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // monitor: check the result beat first, then queue what an accepted byte owes
    always @(posedge i_clk) begin : beat_monitor
        t_cp_result want;
        t_cp_result typed_res;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (cp_expected.size() == 0) begin
                    $error("unexpected result beat: code_point %h end_of_text %b",
                           m_axis_tdata, m_axis_tuser);
                    errors++;
                end else begin
                    want = cp_expected.pop_front();
                    if (m_axis_tdata !== {{(OUT_DATA_W-CP_W){1'b0}}, want.cp}) begin
                        $error("code_point: expected %h, actual %h", want.cp, m_axis_tdata);
                        errors++;
                    end
                    if (m_axis_tuser !== want.eot) begin
                        $error("end_of_text: expected %b, actual %b", want.eot, m_axis_tuser);
                        errors++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last: expected %b, actual %b", want.last, m_axis_tlast);
                        errors++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                decode_byte(s_axis_tdata);
                if (cur_typed) begin
                    typed_res.cp   = cur_cp;
                    typed_res.eot  = cur_eot;
                    typed_res.last = 1'b1;
                    cp_expected    = {cp_expected, typed_res};
                end else begin
                    cp_expected = {cp_expected, byte_results};
                end
            end
        end
    end

    // present one byte at a falling edge and hold it until it is taken
    task automatic send_byte(input t_text_row row);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = row.text_byte;
        cur_typed     = row.typed;
        cur_cp        = row.cp;
        cur_eot       = row.eot;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    initial begin
        // idle mixes: none, sender only, receiver only, both
        int idle_by_phase[4];
        int stall_by_phase[4];
        logic [BYTE_W-1:0] seq_bytes[$];
        logic [BYTE_W-1:0] b;
        int kind, n, n_cont, sent;

        idle_by_phase  = '{0, 54, 0, 33};
        stall_by_phase = '{0, 0, 54, 33};

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < N_DIRECTED; r++)
            send_byte(directed_rows[r]);

        for (int phase = 0; phase < 4; phase++) begin
            idle_pct  = idle_by_phase[phase];
            stall_pct = stall_by_phase[phase];
            sent = 0;
            while (sent < BYTES_PER_PHASE) begin
                seq_bytes.delete();
                kind = $urandom_range(0, 99);
                n = $urandom_range(2, 4);
                if (kind < 20) begin
                    seq_bytes = {seq_bytes, BYTE_W'($urandom_range(1, 127))};
                end else if (kind < 80) begin
                    // well-formed run, or one cut short by a non-continuation byte
                    case (n)
                        2:       seq_bytes = {seq_bytes,
                                              PAT_C0 | BYTE_W'($urandom_range(0, 31))};
                        3:       seq_bytes = {seq_bytes,
                                              PAT_E0 | BYTE_W'($urandom_range(0, 15))};
                        default: seq_bytes = {seq_bytes,
                                              PAT_F0 | BYTE_W'($urandom_range(0, 7))};
                    endcase
                    n_cont = (kind < 65) ? n - 1 : $urandom_range(0, n - 2);
                    repeat (n_cont)
                        seq_bytes = {seq_bytes, PAT_80 | BYTE_W'($urandom_range(0, 63))};
                    if (kind >= 65) begin
                        do b = BYTE_W'($urandom_range(0, 255)); while ((b & MASK_C0) == PAT_80);
                        seq_bytes = {seq_bytes, b};
                    end
                end else if (kind < 87) begin
                    seq_bytes = {seq_bytes, PAT_80 | BYTE_W'($urandom_range(0, 63))};
                end else if (kind < 94) begin
                    seq_bytes = {seq_bytes, MASK_F8 | BYTE_W'($urandom_range(0, 7))};
                end else begin
                    seq_bytes = {seq_bytes, BYTE_W'(0)};
                end
                foreach (seq_bytes[i]) begin
                    send_byte('{text_byte: seq_bytes[i], typed: 1'b0, cp: CP_ZERO, eot: 1'b0});
                    sent++;
                end
            end
        end
        s_axis_tvalid = 1'b0;

        // drain, then keep watching for stray beats
        while (cp_expected.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (cp_expected.size() != 0) begin
            $error("%0d expected results never arrived", cp_expected.size());
            errors++;
        end
        if (errors == 0) begin
            $display("utf8_code_point_decoder verification clean");
        end else begin
            $display("utf8_code_point_decoder verification failed");
        end
        $finish;
    end

    // watchdog against a hung handshake
    initial begin
        #2_000_000;
        $display("utf8_code_point_decoder verification failed");
        $finish;
    end

endmodule
